/* hw/rtl/tbb_pkg.sv */
// ----------------------------------------------------------------------------
// tbb_pkg: shared types and constants of the threshold blur blend core
// Request structs, configuration register codes, reset values and the blend
// arithmetic used by the core.
// ----------------------------------------------------------------------------
package tbb_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SUM_W  = 12;   // nine 8-bit lumas
  localparam int unsigned RECIP_W = 13;
  localparam int unsigned CFG_IDX_W = 2;

  // x / 9 == (x * 7282) >> 16 for every x up to nine full-scale lumas
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam logic [PIX_W-1:0] OPACITY_RESET  = 8'd180;
  localparam logic [PIX_W-1:0] THR_LOW_RESET  = 8'd50;
  localparam logic [PIX_W-1:0] THR_HIGH_RESET = 8'd255;
  localparam logic [PIX_W-1:0] FULL_SCALE     = 8'd255;

  localparam int unsigned FIFO_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OPACITY  = 2'd0,
    CFG_THR_LOW  = 2'd1,
    CFG_THR_HIGH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] a_luma_above;
    logic [PIX_W-1:0] a_luma_centre;
    logic [PIX_W-1:0] a_luma_below;
    logic [PIX_W-1:0] b_luma_above;
    logic [PIX_W-1:0] b_luma_centre;
    logic [PIX_W-1:0] b_luma_below;
    logic [PIX_W-1:0] a_cb;
    logic [PIX_W-1:0] a_cr;
    logic [PIX_W-1:0] b_cb;
    logic [PIX_W-1:0] b_cr;
    logic             edge_row;
    logic             row_end;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_luma;
    logic [PIX_W-1:0] out_cb;
    logic [PIX_W-1:0] out_cr;
    logic             run_last;
  } out_item_t;

  // write side of the result queue: one or two results per cycle
  typedef struct packed {
    logic push;
    logic push_pair;
  } fifo_wr_t;

  // (op0*a + op1*b) >> 8 with op0 = 255 - op1
  function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] op1,
                                           input logic [PIX_W-1:0] a,
                                           input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0]   op0;
    logic [2*PIX_W-1:0] acc;
    op0 = FULL_SCALE - op1;
    acc = ({{PIX_W{1'b0}}, op0} * {{PIX_W{1'b0}}, a})
        + ({{PIX_W{1'b0}}, op1} * {{PIX_W{1'b0}}, b});
    return acc[2*PIX_W-1:PIX_W];
  endfunction

endpackage

/* hw/rtl/threshold_blur_blend_core.sv */
// ----------------------------------------------------------------------------
// threshold_blur_blend_core: column-streaming 3x3 threshold blur with blend
// Holds two pixel columns of frames A and B; emits the centre pixel of the
// previous column, box-blurred and blended where A's luma is out of range.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_valid / in_stall | in_data  (tbb_pkg::in_item_t)
//  out_    | output    | out_valid/out_stall | out_data (tbb_pkg::out_item_t)
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one column request per cycle unless in_stall; a row_end column that follows
//  a held column makes two results, so the output side then sets the pace at
//  one per cycle; a result passes the window/sum register and divide-by-nine
//  register, then is blended and written into the queue
//  in_stall rises when the queue plus results in flight leave fewer than two
//  free entries; cfg_ready is always high
//  reset loads the register defaults and empties the column count and queue
// ----------------------------------------------------------------------------
module threshold_blur_blend_core #(
  parameter int unsigned FifoDepth = tbb_pkg::FIFO_DEPTH  // at least 6
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  tbb_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output tbb_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbb_pkg::PIX_W-1:0]        cfg_data
);

  localparam int unsigned CntW  = $clog2(FifoDepth + 1);
  localparam int unsigned RoomW = CntW + 1;
  localparam int unsigned ProdW = tbb_pkg::SUM_W + tbb_pkg::RECIP_W;

  // configuration
  logic [tbb_pkg::PIX_W-1:0] opacity_r, thr_low_r, thr_high_r;
  logic                      cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r  <= tbb_pkg::OPACITY_RESET;
      thr_low_r  <= tbb_pkg::THR_LOW_RESET;
      thr_high_r <= tbb_pkg::THR_HIGH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        tbb_pkg::CFG_OPACITY:  opacity_r  <= cfg_data;
        tbb_pkg::CFG_THR_LOW:  thr_low_r  <= cfg_data;
        tbb_pkg::CFG_THR_HIGH: thr_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // column window: entries 0..2 older column, 3..5 previous column
  logic [tbb_pkg::PIX_W-1:0] a_win_r [6];
  logic [tbb_pkg::PIX_W-1:0] b_win_r [6];
  logic [tbb_pkg::PIX_W-1:0] chroma_r [4];
  logic                      edge_r;
  logic [1:0]                held_r, held_nxt;
  logic                      accept;

  logic [tbb_pkg::PIX_W-1:0] cur_a [3];
  logic [tbb_pkg::PIX_W-1:0] cur_b [3];
  logic [tbb_pkg::SUM_W-1:0] sum_a, sum_b;
  logic                      emit0, emit1, blur;

  assign accept = in_valid && !in_stall;

  assign cur_a[0] = in_data.a_luma_above;
  assign cur_a[1] = in_data.a_luma_centre;
  assign cur_a[2] = in_data.a_luma_below;
  assign cur_b[0] = in_data.b_luma_above;
  assign cur_b[1] = in_data.b_luma_centre;
  assign cur_b[2] = in_data.b_luma_below;

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int i = 0; i < 6; i++) begin
      sum_a = sum_a + tbb_pkg::SUM_W'(a_win_r[i]);
      sum_b = sum_b + tbb_pkg::SUM_W'(b_win_r[i]);
    end
    for (int i = 0; i < 3; i++) begin
      sum_a = sum_a + tbb_pkg::SUM_W'(cur_a[i]);
      sum_b = sum_b + tbb_pkg::SUM_W'(cur_b[i]);
    end
  end

  assign emit0 = (held_r != 2'd0);
  assign emit1 = in_data.row_end;
  // blur only with both neighbours present and off the border rows
  assign blur  = (held_r == 2'd2) && !edge_r &&
                 ((a_win_r[4] < thr_low_r) || (a_win_r[4] > thr_high_r));

  always_comb begin
    held_nxt = held_r;
    if (accept) begin
      if (in_data.row_end) begin
        held_nxt = 2'd0;
      end else begin
        held_nxt = (held_r != 2'd0) ? 2'd2 : 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 2'd0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_data.row_end) begin
      for (int i = 0; i < 3; i++) begin
        a_win_r[i]     <= a_win_r[3 + i];
        b_win_r[i]     <= b_win_r[3 + i];
        a_win_r[3 + i] <= cur_a[i];
        b_win_r[3 + i] <= cur_b[i];
      end
      chroma_r[0] <= in_data.a_cb;
      chroma_r[1] <= in_data.a_cr;
      chroma_r[2] <= in_data.b_cb;
      chroma_r[3] <= in_data.b_cr;
      edge_r      <= in_data.edge_row;
    end
  end

  // stage 1: sums and the pixels that go out unchanged
  logic                      s1_vld_r, s1_emit0_r, s1_emit1_r, s1_blur_r, s1_last0_r;
  logic [tbb_pkg::SUM_W-1:0] s1_sum_a_r, s1_sum_b_r;
  logic [tbb_pkg::PIX_W-1:0] s1_held_r [5];  // centre luma, a_cb, a_cr, b_cb, b_cr
  logic [tbb_pkg::PIX_W-1:0] s1_pass_r [3];  // current column luma, cb, cr

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit0_r   <= emit0;
      s1_emit1_r   <= emit1;
      s1_blur_r    <= blur;
      s1_last0_r   <= !in_data.row_end;
      s1_sum_a_r   <= sum_a;
      s1_sum_b_r   <= sum_b;
      s1_held_r[0] <= a_win_r[4];
      for (int i = 0; i < 4; i++) begin
        s1_held_r[1 + i] <= chroma_r[i];
      end
      s1_pass_r[0] <= in_data.a_luma_centre;
      s1_pass_r[1] <= in_data.a_cb;
      s1_pass_r[2] <= in_data.a_cr;
    end
  end

  // stage 2: box averages
  logic [ProdW-1:0]          prod_a, prod_b;
  logic                      s2_vld_r, s2_emit0_r, s2_emit1_r, s2_blur_r, s2_last0_r;
  logic [tbb_pkg::PIX_W-1:0] s2_avg_a_r, s2_avg_b_r;
  logic [tbb_pkg::PIX_W-1:0] s2_held_r [5];
  logic [tbb_pkg::PIX_W-1:0] s2_pass_r [3];

  assign prod_a = ProdW'(s1_sum_a_r) * ProdW'(tbb_pkg::RECIP9);
  assign prod_b = ProdW'(s1_sum_b_r) * ProdW'(tbb_pkg::RECIP9);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_emit0_r <= s1_emit0_r;
      s2_emit1_r <= s1_emit1_r;
      s2_blur_r  <= s1_blur_r;
      s2_last0_r <= s1_last0_r;
      s2_avg_a_r <= prod_a[tbb_pkg::RECIP_SHIFT +: tbb_pkg::PIX_W];
      s2_avg_b_r <= prod_b[tbb_pkg::RECIP_SHIFT +: tbb_pkg::PIX_W];
      s2_held_r  <= s1_held_r;
      s2_pass_r  <= s1_pass_r;
    end
  end

  // blend and queue write
  tbb_pkg::out_item_t held_res, pass_res, wr_data0;
  tbb_pkg::fifo_wr_t  fifo_wr;
  logic [CntW-1:0]    fifo_count;
  logic [RoomW-1:0]   room_need;

  always_comb begin
    held_res.run_last = s2_last0_r;
    if (s2_blur_r) begin
      held_res.out_luma = tbb_pkg::mix(opacity_r, s2_avg_a_r, s2_avg_b_r);
      held_res.out_cb   = tbb_pkg::mix(opacity_r, s2_held_r[1], s2_held_r[3]);
      held_res.out_cr   = tbb_pkg::mix(opacity_r, s2_held_r[2], s2_held_r[4]);
    end else begin
      held_res.out_luma = s2_held_r[0];
      held_res.out_cb   = s2_held_r[1];
      held_res.out_cr   = s2_held_r[2];
    end
    pass_res.out_luma = s2_pass_r[0];
    pass_res.out_cb   = s2_pass_r[1];
    pass_res.out_cr   = s2_pass_r[2];
    pass_res.run_last = 1'b1;
  end

  // a lone pass-through result takes the first slot
  assign wr_data0          = s2_emit0_r ? held_res : pass_res;
  assign fifo_wr.push      = s2_vld_r && (s2_emit0_r || s2_emit1_r);
  assign fifo_wr.push_pair = s2_vld_r && s2_emit0_r && s2_emit1_r;

  tbb_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (fifo_wr),
    .wr_data0 (wr_data0),
    .wr_data1 (pass_res),
    .rd_valid (out_valid),
    .rd_stall (out_stall),
    .rd_data  (out_data),
    .count    (fifo_count)
  );

  // reserve two entries for the next request on top of what is in flight
  assign room_need = RoomW'(fifo_count)
                   + RoomW'(s1_vld_r && s1_emit0_r) + RoomW'(s1_vld_r && s1_emit1_r)
                   + RoomW'(s2_vld_r && s2_emit0_r) + RoomW'(s2_vld_r && s2_emit1_r)
                   + RoomW'(2);
  assign in_stall  = (room_need > RoomW'(FifoDepth));

  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.row_end) |=> (held_r == 2'd0))
    else $error("column count not cleared at row end");

  a_blur_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_blur_r) |-> s1_emit0_r)
    else $error("blur flagged without a held column");

  a_pipe_advances: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |=> s2_vld_r)
    else $error("request lost between stages");

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r != 2'd3)
    else $error("column count out of range");

endmodule

/* hw/rtl/tbb_result_fifo.sv */
// ----------------------------------------------------------------------------
// tbb_result_fifo: result queue of the threshold blur blend core
// Takes one or two results per cycle and hands out one result per cycle
// on a valid/stall channel, while rd_stall is low.
// ----------------------------------------------------------------------------
module tbb_result_fifo #(
  parameter int unsigned Depth = tbb_pkg::FIFO_DEPTH,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tbb_pkg::fifo_wr_t   wr,
  input  tbb_pkg::out_item_t  wr_data0,
  input  tbb_pkg::out_item_t  wr_data1,
  output logic                rd_valid,
  input  logic                rd_stall,
  output tbb_pkg::out_item_t  rd_data,
  output logic [CntW-1:0]     count
);

  tbb_pkg::out_item_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_inc;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop        = (count_r != '0) && !rd_stall;
  assign wr_ptr_inc = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (wr.push && wr.push_pair) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_inc);
    end else if (wr.push) begin
      wr_ptr_nxt = wr_ptr_inc;
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CntW'(wr.push) + CntW'(wr.push && wr.push_pair) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem_r[wr_ptr_r] <= wr_data0;
    end
    if (wr.push && wr.push_pair) begin
      mem_r[wr_ptr_inc] <= wr_data1;
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign count    = count_r;

  // the core reserves space before taking a request
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("result queue overflow");

  a_pair_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    wr.push_pair |-> wr.push)
    else $error("second result written without first");

  a_stall_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid && rd_stall && !wr.push) |=> (count_r == $past(count_r)))
    else $error("queue count moved while stalled and idle");

endmodule
